/* sv/mtca_pkg.sv */
// ----------------------------------------------------------------------------
// mtca_pkg
// Shared constants, types and state codes of the multi-tap chorus averager.
// ----------------------------------------------------------------------------
package mtca_pkg;

   localparam int DELAY_DEPTH = 4096;
   localparam int MAX_VOICES  = 16;

   localparam int SAMPLE_W   = 16;
   localparam int LEN_FLD_W  = 13;
   localparam int VC_FLD_W   = 5;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W  = 2;

   localparam int ADDR_W  = $clog2(DELAY_DEPTH);
   localparam int POS_W   = ADDR_W + 1;
   localparam int VOICE_W = $clog2(MAX_VOICES + 1);
   localparam int SUM_W   = SAMPLE_W + $clog2(MAX_VOICES);
   localparam int DIV_W   = (SUM_W > POS_W) ? SUM_W : POS_W;
   localparam int DCNT_W  = $clog2(DIV_W + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ENABLED      = 2'd0,
      REG_DELAY_LENGTH = 2'd1,
      REG_VOICE_COUNT  = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_SPACE,
      ST_READ,
      ST_ACC,
      ST_AVG,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic               enabled;
      logic [POS_W-1:0]   length;
      logic [VOICE_W-1:0] voices;
      logic               pos_clear;
   } cfg_type;

   typedef struct packed {
      logic               start;
      logic [DIV_W-1:0]   dividend;
      logic [VOICE_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

/* sv/mtca_req_if.sv */
// ----------------------------------------------------------------------------
// mtca_req_if
// Request channel carrying one input sample.
// ----------------------------------------------------------------------------
interface mtca_req_if;
   import mtca_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

/* sv/mtca_rsp_if.sv */
// ----------------------------------------------------------------------------
// mtca_rsp_if
// Response channel carrying one output sample.
// ----------------------------------------------------------------------------
interface mtca_rsp_if;
   import mtca_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

/* sv/mtca_csr_if.sv */
// ----------------------------------------------------------------------------
// mtca_csr_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface mtca_csr_if;
   import mtca_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/multi_tap_chorus_averager.sv */
// ----------------------------------------------------------------------------
// multi_tap_chorus_averager
// Multi-tap delay chorus: stores each sample in a circular delay store and
// outputs the truncated average of evenly spaced taps.
//
// Channels: req_bus takes one signed sample per request, rsp_bus returns at
// most one sample per request, csr_bus writes the enabled, delay length and
// voice count registers (always ready; the user must see that they are
// written only while the block is idle, as the block itself has no check
// for it). While disabled a request is taken and dropped without a response.
// One request is worked on at a time, paced by the sequencer and the shared
// one-bit-per-cycle divider. Pass-through (zero or one voice) skips the
// divider. Each tap is one delay store read and one accumulate step.
// Reset disables the block, sets the delay length to 5 and the voice count
// to 1, and clears the write position and the written-entry tracking;
// unwritten delay entries read as zero, so no clearing pass is run.
// A finished response waits in the output register while the receiver stalls;
// one further request may be taken and worked on meanwhile.
// ----------------------------------------------------------------------------
module multi_tap_chorus_averager (
   input  logic clock,
   input  logic reset,
   mtca_req_if.sink   req_bus,
   mtca_rsp_if.source rsp_bus,
   mtca_csr_if.sink   csr_bus
);
   import mtca_pkg::*;

   logic                 enabled_ff, enabled_in;
   logic [LEN_FLD_W-1:0] length_ff, length_in;
   logic [VC_FLD_W-1:0]  voices_ff, voices_in;
   logic                 csr_write;
   logic                 pos_clear;
   cfg_type              cfg;
   div_req_type          div_req;
   div_rsp_type          div_rsp;

   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid && csr_bus.ready;

   always_comb begin
      enabled_in = enabled_ff;
      length_in  = length_ff;
      voices_in  = voices_ff;
      pos_clear  = 1'b0;
      if (csr_write) begin
         unique case (csr_bus.index)
            REG_ENABLED: begin
               enabled_in = csr_bus.data[0];
            end
            REG_DELAY_LENGTH: begin
               length_in = csr_bus.data[LEN_FLD_W-1:0];
               pos_clear = 1'b1;
            end
            REG_VOICE_COUNT: begin
               voices_in = csr_bus.data[VC_FLD_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // effective length and voice count
   always_comb begin
      cfg.enabled   = enabled_ff;
      cfg.pos_clear = pos_clear;
      if (length_ff == '0) begin
         cfg.length = POS_W'(1);
      end else if (32'(length_ff) > DELAY_DEPTH) begin
         cfg.length = POS_W'(DELAY_DEPTH);
      end else begin
         cfg.length = POS_W'(length_ff);
      end
      if (32'(voices_ff) > MAX_VOICES) begin
         cfg.voices = VOICE_W'(MAX_VOICES);
      end else begin
         cfg.voices = VOICE_W'(voices_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
         length_ff  <= LEN_FLD_W'(5);
         voices_ff  <= VC_FLD_W'(1);
      end else begin
         enabled_ff <= enabled_in;
         length_ff  <= length_in;
         voices_ff  <= voices_in;
      end
   end

   mtca_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   mtca_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );
endmodule

/* sv/mtca_ram.sv */
// ----------------------------------------------------------------------------
// mtca_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mtca_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* sv/mtca_div.sv */
// ----------------------------------------------------------------------------
// mtca_div
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module mtca_div (
   input  logic                 clock,
   input  logic                 reset,
   input  mtca_pkg::div_req_type div_req,
   output mtca_pkg::div_rsp_type div_rsp
);
   import mtca_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DCNT_W-1:0]   cnt_ff, cnt_in;
   logic [VOICE_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]    quo_ff, quo_in;
   logic [VOICE_W-1:0]  dvs_ff, dvs_in;
   logic [VOICE_W:0]    trial;
   logic [VOICE_W:0]    diff;
   logic                ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      ge      = (trial >= {1'b0, dvs_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DCNT_W'(DIV_W);
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[VOICE_W-1:0] : trial[VOICE_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;
endmodule

/* sv/mtca_core.sv */
// ----------------------------------------------------------------------------
// mtca_core
// Sequencer and datapath: delay store write, tap walk, accumulation and
// averaging through the shared divider.
// ----------------------------------------------------------------------------
module mtca_core (
   input  logic                  clock,
   input  logic                  reset,
   input  mtca_pkg::cfg_type     cfg,
   mtca_req_if.sink              req_bus,
   mtca_rsp_if.source            rsp_bus,
   output mtca_pkg::div_req_type div_req,
   input  mtca_pkg::div_rsp_type div_rsp
);
   import mtca_pkg::*;

   state_type            state_ff, state_in;
   logic [ADDR_W-1:0]    wp_ff, wp_in;
   logic [ADDR_W-1:0]    hi_ff, hi_in;
   logic                 zero_seen_ff, zero_seen_in;
   logic                 out_valid_ff, out_valid_in;
   logic [SAMPLE_W-1:0]  out_data_ff, out_data_in;
   logic [SAMPLE_W-1:0]  smp_ff, smp_in;
   logic [SAMPLE_W-1:0]  res_ff, res_in;
   logic [POS_W-1:0]     spacing_ff, spacing_in;
   logic [ADDR_W-1:0]    pos_ff, pos_in;
   logic [VOICE_W-1:0]   tap_cnt_ff, tap_cnt_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic                 neg_ff, neg_in;
   logic                 tap_valid_ff, tap_valid_in;

   logic [POS_W-1:0]     wp_inc;
   logic [ADDR_W-1:0]    wp_next;
   logic [POS_W-1:0]     pos_ext;
   logic [ADDR_W-1:0]    pos_next;
   logic                 pos_valid;
   logic [SAMPLE_W-1:0]  rdata;
   logic [SUM_W-1:0]     addend;
   logic [SUM_W-1:0]     acc;
   logic [SUM_W-1:0]     acc_mag;
   logic [DIV_W-1:0]     q_neg;
   logic                 ram_we;

   mtca_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DELAY_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (wp_ff),
      .wdata (smp_ff),
      .raddr (pos_ff),
      .rdata (rdata)
   );

   always_comb begin
      wp_inc    = {1'b0, wp_ff} + 1'b1;
      wp_next   = (wp_inc >= cfg.length) ? '0 : wp_inc[ADDR_W-1:0];
      pos_ext   = {1'b0, pos_ff};
      pos_next  = (pos_ext >= spacing_ff) ? ADDR_W'(pos_ext - spacing_ff)
                                         : ADDR_W'(pos_ext + cfg.length - spacing_ff);
      // entries never written read as zero
      pos_valid = (pos_ff == '0) ? zero_seen_ff : (pos_ff <= hi_ff);
      addend    = tap_valid_ff ? {{(SUM_W-SAMPLE_W){rdata[SAMPLE_W-1]}}, rdata} : '0;
      acc       = sum_ff + addend;
      acc_mag   = acc[SUM_W-1] ? ('0 - acc) : acc;
      q_neg     = '0 - div_rsp.quotient;
   end

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      hi_in        = hi_ff;
      zero_seen_in = zero_seen_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      smp_in       = smp_ff;
      res_in       = res_ff;
      spacing_in   = spacing_ff;
      pos_in       = pos_ff;
      tap_cnt_in   = tap_cnt_ff;
      sum_in       = sum_ff;
      neg_in       = neg_ff;
      tap_valid_in = tap_valid_ff;
      ram_we       = 1'b0;
      div_req      = '0;

      if (out_valid_ff && rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (cfg.pos_clear) begin
               wp_in = '0;
            end
            if (req_bus.valid && cfg.enabled) begin
               wp_in    = wp_next;
               smp_in   = req_bus.sample_in;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            ram_we = 1'b1;
            if (wp_ff == '0) begin
               zero_seen_in = 1'b1;
            end else if (wp_ff > hi_ff) begin
               hi_in = wp_ff;
            end
            if (cfg.voices <= VOICE_W'(1)) begin
               res_in   = smp_ff;
               state_in = ST_OUT;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = DIV_W'(cfg.length);
               div_req.divisor  = cfg.voices - 1'b1;
               state_in         = ST_SPACE;
            end
         end
         ST_SPACE: begin
            if (div_rsp.done) begin
               spacing_in = (div_rsp.quotient == '0) ? '0
                                                     : POS_W'(div_rsp.quotient - 1'b1);
               pos_in     = wp_ff;
               tap_cnt_in = '0;
               sum_in     = '0;
               state_in   = ST_READ;
            end
         end
         ST_READ: begin
            tap_valid_in = pos_valid;
            pos_in       = pos_next;
            state_in     = ST_ACC;
         end
         ST_ACC: begin
            sum_in     = acc;
            tap_cnt_in = tap_cnt_ff + 1'b1;
            if (VOICE_W'(tap_cnt_ff + 1'b1) == cfg.voices) begin
               div_req.start    = 1'b1;
               div_req.dividend = DIV_W'(acc_mag);
               div_req.divisor  = cfg.voices;
               neg_in           = acc[SUM_W-1];
               state_in         = ST_AVG;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_AVG: begin
            if (div_rsp.done) begin
               res_in   = neg_ff ? q_neg[SAMPLE_W-1:0] : div_rsp.quotient[SAMPLE_W-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!out_valid_ff || rsp_bus.ready) begin
               out_valid_in = 1'b1;
               out_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         hi_ff        <= '0;
         zero_seen_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         hi_ff        <= hi_in;
         zero_seen_ff <= zero_seen_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      smp_ff       <= smp_in;
      res_ff       <= res_in;
      spacing_ff   <= spacing_in;
      pos_ff       <= pos_in;
      tap_cnt_ff   <= tap_cnt_in;
      sum_ff       <= sum_in;
      neg_ff       <= neg_in;
      tap_valid_ff <= tap_valid_in;
   end

   assign req_bus.ready      = (state_ff == ST_IDLE);
   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.sample_out = out_data_ff;
endmodule
